// ===== src/sdpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, opcodes and constants of the step/direction pulse generator.
// No dependencies.
package sdpg_pkg;

   localparam int RATE_W      = 20;
   localparam int HALF_W      = 19;
   localparam int ELAPSED_W   = 20;
   localparam int OP_W        = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = RATE_W;
   localparam int DIVISOR_W   = RATE_W + 1;
   localparam int QUOT_W      = 20;
   localparam int DIV_STEPS   = QUOT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [QUOT_W-1:0]    US_PER_SECOND = QUOT_W'(1000000);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};

   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_ENABLE  = 3'd1;
   localparam logic [OP_W-1:0] OP_DISABLE = 3'd2;
   localparam logic [OP_W-1:0] OP_START   = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP    = 3'd4;
   localparam logic [OP_W-1:0] OP_SET_DIR = 3'd5;
   localparam logic [OP_W-1:0] OP_STEP    = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_SECOND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ENABLE_LINE  = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            new_direction;
   } req_type;

   typedef struct packed {
      logic step_level;
      logic direction_level;
      logic enable_n;
      logic is_running;
      logic is_enabled;
   } rsp_type;

   typedef struct packed {
      logic cfg_write;
      logic div_start;
      logic div_step;
      logic div_finish;
      logic item_apply;
   } cmd_type;

endpackage

// ===== src/sdpg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: handshakes, result valid and the half-period divide sequence.
// Depends on sdpg_pkg.
module sdpg_ctrl import sdpg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   output cmd_type              cmd
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign csr_ready = (state_ff == IDLE);
   assign req_stall = (state_ff != IDLE) || (rsp_valid_ff && rsp_stall) || csr_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.cfg_write  = csr_valid && csr_ready;
      cmd.div_start  = cmd.cfg_write && (csr_index == CSR_STEPS_PER_SECOND);
      cmd.div_step   = (state_ff == DIVIDE);
      cmd.div_finish = (state_ff == FINISH);
      cmd.item_apply = req_valid && !req_stall;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.item_apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE: begin
            count_in = '0;
            if (cmd.div_start) begin
               state_in = DIVIDE;
            end
         end
         DIVIDE: begin
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_item_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> !cmd.item_apply)
      else $error("item applied during divide");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE) |-> (count_ff < DIV_CNT_W'(DIV_STEPS)))
      else $error("divide counter out of range");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result dropped");
   a_finish_returns: assert property (@(posedge clock) disable iff (reset)
      cmd.div_finish |=> (state_ff == IDLE))
      else $error("divide did not return to idle");

endmodule

// ===== src/sdpg_dp.sv =====
`timescale 1ns / 1ps
// Datapath: control flags, tick counter, serial half-period divider and result register.
// Depends on sdpg_pkg.
module sdpg_dp import sdpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  req_type               req_data,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output rsp_type               rsp_data
);

   logic                 enabled_ff, enabled_in;
   logic                 running_ff, running_in;
   logic                 step_ff, step_in;
   logic                 dir_ff, dir_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [HALF_W-1:0]    half_ff, half_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic                 has_en_ff, has_en_in;

   logic [DIVISOR_W-1:0] divisor_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [QUOT_W-1:0]    quot_ff;
   rsp_type              rsp_ff;

   logic [DIVISOR_W:0]   trial;
   logic                 fits;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic                 pulse;

   assign trial = {rem_ff, quot_ff[QUOT_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      running_in = running_ff;
      step_in    = step_ff;
      dir_in     = dir_ff;
      elapsed_in = elapsed_ff;
      half_in    = half_ff;
      rate_in    = rate_ff;
      has_en_in  = has_en_ff;
      pulse      = 1'b0;
      if (cmd.cfg_write) begin
         if (csr_index == CSR_STEPS_PER_SECOND) begin
            rate_in = csr_wdata;
            if (csr_wdata == '0) begin
               running_in = 1'b0;
               step_in    = 1'b0;
            end
         end else begin
            has_en_in = csr_wdata[0];
         end
      end
      if (cmd.div_finish) begin
         if (rate_ff == '0) begin
            half_in = '0;
         end else if (quot_ff == '0) begin
            half_in = HALF_W'(1);
         end else begin
            half_in = quot_ff[HALF_W-1:0];
         end
      end
      if (cmd.item_apply) begin
         unique case (req_data.opcode)
            OP_TICK: begin
               if (enabled_ff && running_ff && (half_ff != '0)) begin
                  if (elapsed_inc >= ELAPSED_W'(half_ff)) begin
                     elapsed_in = '0;
                     step_in    = !step_ff;
                  end else begin
                     elapsed_in = elapsed_inc;
                  end
               end
            end
            OP_ENABLE: begin
               enabled_in = 1'b1;
            end
            OP_DISABLE: begin
               running_in = 1'b0;
               step_in    = 1'b0;
               enabled_in = 1'b0;
            end
            OP_START: begin
               if (enabled_ff && (rate_ff != '0)) begin
                  elapsed_in = '0;
                  running_in = 1'b1;
               end
            end
            OP_STOP: begin
               running_in = 1'b0;
               step_in    = 1'b0;
            end
            OP_SET_DIR: begin
               running_in = 1'b0;
               step_in    = 1'b0;
               dir_in     = req_data.new_direction;
               if (running_ff && enabled_ff && (rate_ff != '0)) begin
                  elapsed_in = '0;
                  running_in = 1'b1;
               end
            end
            OP_STEP: begin
               pulse = enabled_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         running_ff <= 1'b0;
         step_ff    <= 1'b0;
         dir_ff     <= 1'b1;
         elapsed_ff <= '0;
         half_ff    <= '0;
         rate_ff    <= '0;
         has_en_ff  <= 1'b1;
      end else begin
         enabled_ff <= enabled_in;
         running_ff <= running_in;
         step_ff    <= step_in;
         dir_ff     <= dir_in;
         elapsed_ff <= elapsed_in;
         half_ff    <= half_in;
         rate_ff    <= rate_in;
         has_en_ff  <= has_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         divisor_ff <= {csr_wdata, 1'b0};
         rem_ff     <= '0;
         quot_ff    <= US_PER_SECOND;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         quot_ff <= {quot_ff[QUOT_W-2:0], fits};
      end
      if (cmd.item_apply) begin
         rsp_ff.step_level      <= pulse || step_in;
         rsp_ff.direction_level <= dir_in;
         rsp_ff.enable_n        <= has_en_ff ? !enabled_in : 1'b1;
         rsp_ff.is_running      <= running_in;
         rsp_ff.is_enabled      <= enabled_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/step_dir_pulse_generator.sv =====
`timescale 1ns / 1ps
// Top level of the step/direction pulse generator: controller plus datapath.
// Depends on sdpg_pkg, sdpg_ctrl and sdpg_dp.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_stall  req_type (opcode, new_direction)
//   rsp_        out        rsp_valid/rsp_stall  rsp_type (line levels and flags)
//   csr_        in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A request is applied in the cycle it is accepted; its result is registered
// and shows in the next cycle. A new request is taken while that result waits
// unless rsp_stall is high; a pending csr_valid or a divide also holds it off.
// A steps_per_second write runs the 20-step serial divider, then FINISH, with
// requests held off. Sync reset clears enable/run; dir_ff resets high.
module step_dir_pulse_generator import sdpg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;

   sdpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .cmd       (cmd)
   );

   sdpg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule
